// ----- design/bytecode_interpreter_core_top_assert.svh -----
// assertion macros used by the core top rtl file
`ifndef BYTECODE_INTERPRETER_CORE_TOP_ASSERT_SVH
`define BYTECODE_INTERPRETER_CORE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BIC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("bic assertion failed");
`define BIC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bic assertion failed");
`else
`define BIC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BIC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- design/bic_pkg.sv -----
`default_nettype none
package bic_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int ADDR_W        = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH   = 16;
  localparam int SP_W          = $clog2(STACK_DEPTH);
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
  localparam int NUM_REGS      = 16;
  localparam int REG_W         = $clog2(NUM_REGS);
  localparam int GLYPH_BYTES   = 80;

  localparam logic [ADDR_W-1:0] START_PC   = 12'h200;
  localparam logic [ADDR_W-1:0] GLYPH_BASE = 12'h050;
  localparam logic [ADDR_W-1:0] ADDR_MAX   = 12'hFFF;
  localparam logic [15:0]       SEED_RESET = 16'd44257;

  // item kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_EXEC = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // opcode groups (top nibble)
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SE   = 4'h3;
  localparam logic [3:0] OP_SNE  = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV  = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  // low byte codes
  localparam logic [7:0] KK_CLS  = 8'hE0;
  localparam logic [7:0] KK_RET  = 8'hEE;
  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;
  localparam logic [7:0] KK_GDT  = 8'h07;
  localparam logic [7:0] KK_WKEY = 8'h0A;
  localparam logic [7:0] KK_SDT  = 8'h15;
  localparam logic [7:0] KK_SST  = 8'h18;
  localparam logic [7:0] KK_ADDI = 8'h1E;
  localparam logic [7:0] KK_FONT = 8'h29;
  localparam logic [7:0] KK_BCD  = 8'h33;
  localparam logic [7:0] KK_STR  = 8'h55;
  localparam logic [7:0] KK_LDR  = 8'h65;

  // alu sub-ops
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [3:0] REG_FLAG = 4'hF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [15:0] key_state;
    logic [4:0]  row_select;
  } in_item_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [15:0] executed_opcode;
    logic        screen_changed;
    logic        sound_active;
    logic        waiting_key;
    logic [63:0] row_pixels;
  } out_item_t;

  localparam logic [7:0] GLYPH_ROM [GLYPH_BYTES] = '{
    8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
    8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
    8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
    8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
    8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
    8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
    8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
    8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
  };

  // power-up image of one memory byte
  function automatic logic [7:0] boot_byte(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] off;
    off = addr - GLYPH_BASE;
    if (addr >= GLYPH_BASE && off < ADDR_W'(GLYPH_BYTES)) begin
      return GLYPH_ROM[off[6:0]];
    end
    return 8'h00;
  endfunction

  // decimal digit of v: sel 0 hundreds, 1 tens, 2 ones
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [15:0] prod;
    logic [3:0]  t;
    logic [7:0]  o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
    prod = {8'b0, r} * 16'd205;
    t = prod[14:11];
    o = r - {t, 3'b000} - {3'b000, t, 1'b0};
    case (sel)
      2'd0:    return {6'b0, h};
      2'd1:    return {4'b0, t};
      default: return o;
    endcase
  endfunction

  function automatic logic [REG_W-1:0] first_key(input logic [15:0] keys);
    logic [REG_W-1:0] k;
    k = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (keys[i]) k = REG_W'(i);
    end
    return k;
  endfunction

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = {1'b0, v[15:1]};
    if (v[0]) s = s ^ 16'hB400;
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- design/bytecode_interpreter_core_top.sv -----
// one item in flight; the memory port paces each step of a load, row read, execute, bcd,
//   draw or register block save/load
// a new item is accepted only in idle, after the last result reaches the output register, where it may wait
// reset: synchronous active-low; after reset a pass over every address writes the font and
//   zeros into main memory, and no item is accepted until it ends
`default_nettype none
`include "bytecode_interpreter_core_top_assert.svh"
module bytecode_interpreter_core_top
  import bic_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  // one-hot sequencer states
  typedef enum logic [15:0] {
    S_CLR   = 16'b0000_0000_0000_0001,  // memory boot pass: font and zeros
    S_IDLE  = 16'b0000_0000_0000_0010,
    S_F1    = 16'b0000_0000_0000_0100,  // opcode high byte
    S_F2    = 16'b0000_0000_0000_1000,  // opcode low byte
    S_RX    = 16'b0000_0000_0001_0000,  // vx arrives
    S_RY    = 16'b0000_0000_0010_0000,  // vy (or v0) arrives
    S_EX    = 16'b0000_0000_0100_0000,
    S_WB    = 16'b0000_0000_1000_0000,  // alu result after flag
    S_DRD   = 16'b0000_0001_0000_0000,  // sprite line + screen row read
    S_DWR   = 16'b0000_0010_0000_0000,  // xor and write back
    S_DFLAG = 16'b0000_0100_0000_0000,
    S_BCD   = 16'b0000_1000_0000_0000,
    S_MRD   = 16'b0001_0000_0000_0000,  // block move read
    S_MWR   = 16'b0010_0000_0000_0000,  // block move write
    S_ROW   = 16'b0100_0000_0000_0000,
    S_FIN   = 16'b1000_0000_0000_0000   // result to output register
  } state_t;

  state_t state_r, state_nxt;

  // architectural state kept in flops
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic [15:0]       i_r, i_nxt;
  logic [SP_W-1:0]   sl_r, sl_nxt;
  logic [ADDR_W-1:0] stack_r [STACK_DEPTH];
  logic [ADDR_W-1:0] stack_nxt [STACK_DEPTH];
  logic [7:0]        dt_r, dt_nxt;
  logic [7:0]        st_r, st_nxt;
  logic [15:0]       lfsr_r, lfsr_nxt;
  logic [NUM_REGS-1:0]      vvalid_r, vvalid_nxt;
  logic [SCREEN_HEIGHT-1:0] svalid_r, svalid_nxt;

  // per-item working registers
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [15:0]       keys_r, keys_nxt;
  logic [15:0]       op_r, op_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic [7:0]        vx_r, vx_nxt;
  logic [7:0]        vy_r, vy_nxt;
  logic [7:0]        wb_r, wb_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              coll_r, coll_nxt;
  logic              drew_r, drew_nxt;
  logic              wait_r, wait_nxt;
  logic [63:0]       row_r, row_nxt;
  logic              vhit_r, vhit_nxt;
  logic              shit_r, shit_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // memory ports
  logic [ADDR_W-1:0] m_addr;
  logic              m_we;
  logic [7:0]        m_wdata, m_rdata;
  logic [REG_W-1:0]  v_addr;
  logic              v_we;
  logic [7:0]        v_wdata, v_rdata;
  logic [ROW_W-1:0]  s_addr;
  logic              s_we;
  logic [63:0]       s_wdata, s_rdata;

  bic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
  );

  bic_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_reg_file (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
  );

  bic_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_screen (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
  );

  // opcode fields
  logic [3:0]  grp, fx, fy, nib;
  logic [7:0]  kk;
  logic [11:0] nnn;
  assign grp = op_r[15:12];
  assign fx  = op_r[11:8];
  assign fy  = op_r[7:4];
  assign nib = op_r[3:0];
  assign kk  = op_r[7:0];
  assign nnn = op_r[11:0];

  // entries never written read as zero
  logic [7:0]  vrd;
  logic [63:0] srd;
  assign vrd = vhit_r ? v_rdata : 8'h00;
  assign srd = shit_r ? s_rdata : 64'h0;

  logic [5:0]        ysum;
  logic [ADDR_W-1:0] idx_addr;
  logic [63:0]       mask;
  logic [8:0]        add_sum;
  logic [15:0]       lfsr_adv;
  assign ysum     = {1'b0, vy_r[4:0]} + {2'b00, cnt_r};
  assign idx_addr = i_r[ADDR_W-1:0] + {8'b0, cnt_r};
  assign mask     = {m_rdata, 56'h0} >> vx_r[5:0];
  assign add_sum  = {1'b0, vx_r} + {1'b0, vy_r};
  assign lfsr_adv = lfsr_step(lfsr_r);

  logic in_acc;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    i_nxt         = i_r;
    sl_nxt        = sl_r;
    stack_nxt     = stack_r;
    dt_nxt        = dt_r;
    st_nxt        = st_r;
    lfsr_nxt      = lfsr_r;
    vvalid_nxt    = vvalid_r;
    svalid_nxt    = svalid_r;
    clr_nxt       = clr_r;
    kind_nxt      = kind_r;
    keys_nxt      = keys_r;
    op_nxt        = op_r;
    hi_nxt        = hi_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    wb_nxt        = wb_r;
    cnt_nxt       = cnt_r;
    coll_nxt      = coll_r;
    drew_nxt      = drew_r;
    wait_nxt      = wait_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    m_addr  = '0;
    m_we    = 1'b0;
    m_wdata = '0;
    v_addr  = '0;
    v_we    = 1'b0;
    v_wdata = '0;
    s_addr  = '0;
    s_we    = 1'b0;
    s_wdata = '0;

    unique case (state_r)
      S_CLR: begin
        m_addr  = clr_r;
        m_we    = 1'b1;
        m_wdata = boot_byte(clr_r);
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_MAX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          kind_nxt = in_data.kind;
          keys_nxt = in_data.key_state;
          drew_nxt = 1'b0;
          wait_nxt = 1'b0;
          row_nxt  = '0;
          op_nxt   = '0;
          case (in_data.kind)
            KIND_LOAD: begin
              m_we      = 1'b1;
              m_addr    = in_data.load_address;
              m_wdata   = in_data.load_byte;
              state_nxt = S_FIN;
            end
            KIND_EXEC: begin
              m_addr    = pc_r;
              state_nxt = S_F1;
            end
            KIND_READ: begin
              s_addr    = in_data.row_select;
              state_nxt = S_ROW;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_ROW: begin
        row_nxt   = srd;
        state_nxt = S_FIN;
      end

      S_F1: begin
        hi_nxt    = m_rdata;
        m_addr    = pc_r + 1'b1;
        state_nxt = S_F2;
      end

      S_F2: begin
        op_nxt    = {hi_r, m_rdata};
        pc_nxt    = pc_r + 12'd2;
        v_addr    = hi_r[3:0];
        state_nxt = S_RX;
      end

      S_RX: begin
        vx_nxt    = vrd;
        // jump with offset needs v0 in place of vy
        v_addr    = (grp == OP_JPV) ? '0 : fy;
        state_nxt = S_RY;
      end

      S_RY: begin
        vy_nxt    = vrd;
        state_nxt = S_EX;
      end

      S_EX: begin
        state_nxt = S_FIN;
        case (grp)
          OP_SYS: begin
            if (kk == KK_CLS) begin
              svalid_nxt = '0;
              drew_nxt   = 1'b1;
            end else if (kk == KK_RET) begin
              sl_nxt = sl_r - 1'b1;
              pc_nxt = stack_r[sl_r - 1'b1];
            end
          end
          OP_JP: pc_nxt = nnn;
          OP_CALL: begin
            stack_nxt[sl_r] = pc_r;
            sl_nxt          = sl_r + 1'b1;
            pc_nxt          = nnn;
          end
          OP_SE:   if (vx_r == kk)   pc_nxt = pc_r + 12'd2;
          OP_SNE:  if (vx_r != kk)   pc_nxt = pc_r + 12'd2;
          OP_SER:  if (vx_r == vy_r) pc_nxt = pc_r + 12'd2;
          OP_SNER: if (vx_r != vy_r) pc_nxt = pc_r + 12'd2;
          OP_LD: begin
            v_we = 1'b1; v_addr = fx; v_wdata = kk;
          end
          OP_ADD: begin
            v_we = 1'b1; v_addr = fx; v_wdata = vx_r + kk;
          end
          OP_ALU: begin
            case (nib)
              ALU_MOV: begin v_we = 1'b1; v_addr = fx; v_wdata = vy_r; end
              ALU_OR:  begin v_we = 1'b1; v_addr = fx; v_wdata = vx_r | vy_r; end
              ALU_AND: begin v_we = 1'b1; v_addr = fx; v_wdata = vx_r & vy_r; end
              ALU_XOR: begin v_we = 1'b1; v_addr = fx; v_wdata = vx_r ^ vy_r; end
              // flag first, result next cycle, so a result that targets vf overwrites the flag
              ALU_ADD: begin
                v_we = 1'b1; v_addr = REG_FLAG; v_wdata = {7'b0, add_sum[8]};
                wb_nxt = add_sum[7:0]; state_nxt = S_WB;
              end
              ALU_SUB: begin
                v_we = 1'b1; v_addr = REG_FLAG; v_wdata = {7'b0, vx_r > vy_r};
                wb_nxt = vx_r - vy_r; state_nxt = S_WB;
              end
              ALU_SHR: begin
                v_we = 1'b1; v_addr = REG_FLAG; v_wdata = {7'b0, vx_r[0]};
                wb_nxt = {1'b0, vx_r[7:1]}; state_nxt = S_WB;
              end
              ALU_SUBN: begin
                v_we = 1'b1; v_addr = REG_FLAG; v_wdata = {7'b0, vy_r > vx_r};
                wb_nxt = vy_r - vx_r; state_nxt = S_WB;
              end
              ALU_SHL: begin
                v_we = 1'b1; v_addr = REG_FLAG; v_wdata = {7'b0, vx_r[7]};
                wb_nxt = {vx_r[6:0], 1'b0}; state_nxt = S_WB;
              end
              default: ;
            endcase
          end
          OP_LDI: i_nxt = {4'b0, nnn};
          OP_JPV: pc_nxt = nnn + {4'b0, vy_r};
          OP_RND: begin
            lfsr_nxt = lfsr_adv;
            v_we = 1'b1; v_addr = fx; v_wdata = lfsr_adv[7:0] & kk;
          end
          OP_DRW: begin
            cnt_nxt   = '0;
            coll_nxt  = 1'b0;
            drew_nxt  = 1'b1;
            state_nxt = S_DRD;
          end
          OP_KEY: begin
            if (kk == KK_SKP && keys_r[vx_r[3:0]]) begin
              pc_nxt = pc_r + 12'd2;
            end else if (kk == KK_SKNP && !keys_r[vx_r[3:0]]) begin
              pc_nxt = pc_r + 12'd2;
            end
          end
          default: begin
            case (kk)
              KK_GDT: begin v_we = 1'b1; v_addr = fx; v_wdata = dt_r; end
              KK_WKEY: begin
                if (keys_r != 16'h0) begin
                  v_we = 1'b1; v_addr = fx; v_wdata = {4'b0, first_key(keys_r)};
                end else begin
                  pc_nxt   = pc_r - 12'd2;
                  wait_nxt = 1'b1;
                end
              end
              KK_SDT:  dt_nxt = vx_r;
              KK_SST:  st_nxt = vx_r;
              KK_ADDI: i_nxt = i_r + {8'b0, vx_r};
              KK_FONT: i_nxt = {4'b0, GLYPH_BASE} + {6'b0, vx_r, 2'b00} + {8'b0, vx_r};
              KK_BCD: begin
                cnt_nxt = '0; state_nxt = S_BCD;
              end
              KK_STR, KK_LDR: begin
                cnt_nxt = '0; state_nxt = S_MRD;
              end
              default: ;
            endcase
          end
        endcase
      end

      S_WB: begin
        v_we = 1'b1; v_addr = fx; v_wdata = wb_r;
        state_nxt = S_FIN;
      end

      S_DRD: begin
        // stop at sprite height or bottom edge
        if (cnt_r == nib || ysum[5]) begin
          state_nxt = S_DFLAG;
        end else begin
          m_addr    = idx_addr;
          s_addr    = ysum[ROW_W-1:0];
          state_nxt = S_DWR;
        end
      end

      S_DWR: begin
        s_we    = 1'b1;
        s_addr  = ysum[ROW_W-1:0];
        s_wdata = srd ^ mask;
        svalid_nxt[ysum[ROW_W-1:0]] = 1'b1;
        coll_nxt  = coll_r | (|(srd & mask));
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_DRD;
      end

      S_DFLAG: begin
        v_we = 1'b1; v_addr = REG_FLAG; v_wdata = {7'b0, coll_r};
        state_nxt = S_FIN;
      end

      S_BCD: begin
        m_we    = 1'b1;
        m_addr  = idx_addr;
        m_wdata = bcd_digit(vx_r, cnt_r[1:0]);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'd2) begin
          state_nxt = S_FIN;
        end
      end

      S_MRD: begin
        if (kk == KK_STR) begin
          v_addr = cnt_r;
        end else begin
          m_addr = idx_addr;
        end
        state_nxt = S_MWR;
      end

      S_MWR: begin
        if (kk == KK_STR) begin
          m_we = 1'b1; m_addr = idx_addr; m_wdata = vrd;
        end else begin
          v_we = 1'b1; v_addr = cnt_r; v_wdata = m_rdata;
        end
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = (cnt_r == fx) ? S_FIN : S_MRD;
      end

      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          if (kind_r == KIND_EXEC) begin
            dt_nxt = dt_r - {7'b0, dt_r != 8'h0};
            st_nxt = st_r - {7'b0, st_r != 8'h0};
          end
          out_valid_nxt                = 1'b1;
          out_data_nxt.next_pc         = pc_r;
          out_data_nxt.executed_opcode = op_r;
          out_data_nxt.screen_changed  = drew_r;
          out_data_nxt.sound_active    = (kind_r == KIND_EXEC) ? (st_r > 8'd1)
                                                               : (st_r != 8'h0);
          out_data_nxt.waiting_key     = wait_r;
          out_data_nxt.row_pixels      = row_r;
          state_nxt                    = S_IDLE;
        end
      end

      default: state_nxt = S_CLR;
    endcase

    if (v_we) begin
      vvalid_nxt[v_addr] = 1'b1;
    end
    vhit_nxt = vvalid_r[v_addr];
    shit_nxt = svalid_r[s_addr];

    // seed write reloads the lfsr at once
    if (cfg_we) begin
      lfsr_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      pc_r        <= START_PC;
      i_r         <= '0;
      sl_r        <= '0;
      dt_r        <= '0;
      st_r        <= '0;
      lfsr_r      <= SEED_RESET;
      vvalid_r    <= '0;
      svalid_r    <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < STACK_DEPTH; k++) begin
        stack_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pc_r        <= pc_nxt;
      i_r         <= i_nxt;
      sl_r        <= sl_nxt;
      dt_r        <= dt_nxt;
      st_r        <= st_nxt;
      lfsr_r      <= lfsr_nxt;
      vvalid_r    <= vvalid_nxt;
      svalid_r    <= svalid_nxt;
      out_valid_r <= out_valid_nxt;
      stack_r     <= stack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    keys_r     <= keys_nxt;
    op_r       <= op_nxt;
    hi_r       <= hi_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    wb_r       <= wb_nxt;
    cnt_r      <= cnt_nxt;
    coll_r     <= coll_nxt;
    drew_r     <= drew_nxt;
    wait_r     <= wait_nxt;
    row_r      <= row_nxt;
    vhit_r     <= vhit_nxt;
    shit_r     <= shit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a waiting result is never overwritten
  `BIC_ASSERT_NXT(a_fin_holds, clk, rst_n, (state_r == S_FIN) && out_valid_r && !out_ready, state_r == S_FIN)
  // sprite rows are clipped before any screen write
  `BIC_ASSERT_IMP(a_draw_clip, clk, rst_n, state_r == S_DWR, !ysum[5])
  // an accepted execute item starts its fetch
  `BIC_ASSERT_NXT(a_exec_fetch, clk, rst_n, in_acc && (in_data.kind == KIND_EXEC), state_r == S_F1)

endmodule
`default_nettype wire

// ----- design/bic_ram.sv -----
`default_nettype none
module bic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire
